### rtl/core/bvt_pkg.sv
package bvt_pkg;

    localparam int CAPACITY     = 1024;
    localparam int ADDR_W       = $clog2(CAPACITY);
    localparam int LEN_W        = $clog2(CAPACITY + 1);
    localparam int CMD_W        = 3;
    localparam int INDEX_W      = 10;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int LENGTH_NOW_W = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_READ   = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

### rtl/core/bvt_if.sv
interface bvt_req_if
    import bvt_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [INDEX_W-1:0]        index;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output command, output index, output value, input ready);
    modport sink   (input valid, input command, input index, input value, output ready);
endinterface

interface bvt_rsp_if
    import bvt_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  read_data;
    logic [STATUS_W-1:0]       status;
    logic [LENGTH_NOW_W-1:0]   length_now;

    modport source (output valid, output read_data, output status, output length_now,
                    input ready);
    modport sink   (input valid, input read_data, input status, input length_now,
                    output ready);
endinterface

### rtl/core/bounded_vector_table_core.sv
// Bounded vector table: a fixed-capacity vector of 32-bit elements in one
// synchronous memory, with a length register.
// The req channel carries one request per command (append, read, write,
// delete, clear); the rsp channel returns exactly one response per request
// with the element read, a status code and the length after the command.
// Requests are taken one at a time; ready is high only while the block waits
// for a new request. Each command passes through these states before the
// block is idle again:
//   append, clear, in-range write, other rejections: the response state.
//   read, also out of range when not empty: a read wait, then response.
//   write past the end: a fill state, one zero-fill write per cycle on
//     the single write port, the value last, then the response state.
//   delete in range: a read state and a write state for each element
//     moved down, then a final read state and the response state.
// The response is held in an output register; a new request is accepted while
// it waits. If the receiver stalls, the next response waits until the output
// register is taken.
// Reset clears the length and all control state; memory contents are left
// undefined and no entry is read before it is written.
module bounded_vector_table_core
    import bvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bvt_req_if.sink   req,
    bvt_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_WAIT,
        S_FILL,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESP
    } state_t;

    logic [DATA_W-1:0] mem [CAPACITY];

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         length_reg, length_next;
    logic [LEN_W-1:0]         ptr_reg, ptr_next;
    logic [LEN_W-1:0]         idx_reg, idx_next;
    logic [DATA_W-1:0]        val_reg, val_next;
    logic [DATA_W-1:0]        pend_rd_reg, pend_rd_next;
    status_t                  pend_st_reg, pend_st_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        out_rd_reg, out_rd_next;
    status_t                  out_st_reg, out_st_next;
    logic [LENGTH_NOW_W-1:0]  out_len_reg, out_len_next;
    logic [DATA_W-1:0]        rd_data_reg;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr;

    logic                     accept;
    logic [LEN_W-1:0]         ptr_inc;

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    assign ptr_inc       = ptr_reg + LEN_W'(1);

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_rd_reg;
    assign rsp.status     = out_st_reg;
    assign rsp.length_now = out_len_reg;

    always_comb
    begin
        state_next     = state_reg;
        length_next    = length_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        pend_rd_next   = pend_rd_reg;
        pend_st_next   = pend_st_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_rd_next    = out_rd_reg;
        out_st_next    = out_st_reg;
        out_len_next   = out_len_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg[ADDR_W-1:0];
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_rd_next = '0;
                    pend_st_next = ST_OK;
                    idx_next     = LEN_W'(req.index);
                    val_next     = req.value;
                    state_next   = S_RESP;
                    case (cmd_t'(req.command))
                        CMD_APPEND:
                        begin
                            if (32'(length_reg) >= 32'(CAPACITY))
                            begin
                                pend_st_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = length_reg[ADDR_W-1:0];
                                mem_wdata   = req.value;
                                length_next = length_reg + LEN_W'(1);
                            end
                        end
                        CMD_READ:
                        begin
                            if (32'(req.index) < 32'(length_reg))
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = ADDR_W'(req.index);
                                state_next = S_READ_WAIT;
                            end
                            else
                            begin
                                pend_st_next = ST_RANGE;
                                if (length_reg != '0)
                                begin
                                    mem_re     = 1'b1;
                                    state_next = S_READ_WAIT;
                                end
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (32'(req.index) < 32'(length_reg))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = ADDR_W'(req.index);
                                mem_wdata = req.value;
                            end
                            else if (32'(req.index) >= 32'(CAPACITY))
                            begin
                                pend_st_next = ST_FULL;
                            end
                            else
                            begin
                                ptr_next   = length_reg;
                                state_next = S_FILL;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (32'(req.index) >= 32'(length_reg))
                            begin
                                pend_st_next = ST_RANGE;
                            end
                            else
                            begin
                                ptr_next   = LEN_W'(req.index);
                                state_next = S_SHIFT_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            length_next = '0;
                        end
                        default:
                        begin
                            pend_st_next = ST_RANGE;
                        end
                    endcase
                end
            end
            S_READ_WAIT:
            begin
                pend_rd_next = rd_data_reg;
                state_next   = S_RESP;
            end
            S_FILL:
            begin
                mem_we = 1'b1;
                if (ptr_reg == idx_reg)
                begin
                    mem_wdata   = val_reg;
                    length_next = idx_reg + LEN_W'(1);
                    state_next  = S_RESP;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            S_SHIFT_RD:
            begin
                if (ptr_inc >= length_reg)
                begin
                    length_next = length_reg - LEN_W'(1);
                    state_next  = S_RESP;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_inc[ADDR_W-1:0];
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rd_data_reg;
                ptr_next   = ptr_inc;
                state_next = S_SHIFT_RD;
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = pend_rd_reg;
                    out_st_next    = pend_st_reg;
                    out_len_next   = LENGTH_NOW_W'(length_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            length_reg    <= '0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            val_reg       <= '0;
            pend_rd_reg   <= '0;
            pend_st_reg   <= ST_OK;
            out_valid_reg <= 1'b0;
            out_rd_reg    <= '0;
            out_st_reg    <= ST_OK;
            out_len_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            ptr_reg       <= ptr_next;
            idx_reg       <= idx_next;
            val_reg       <= val_next;
            pend_rd_reg   <= pend_rd_next;
            pend_st_reg   <= pend_st_next;
            out_valid_reg <= out_valid_next;
            out_rd_reg    <= out_rd_next;
            out_st_reg    <= out_st_next;
            out_len_reg   <= out_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule
